// ----- hdl/n2a_pkg.sv -----
// Shared types, constants and helper functions for the number to ASCII digits block.
// Used by the digit cell and by the top level; depends on nothing else.
package n2a_pkg;

    // Width of the number port and the default internal number width.
    localparam int NUMBER_BITS      = 32;
    localparam int NUMBER_WIDTH_DEF = 32;

    // Number of BCD digit cells in the conversion row.
    localparam int NUM_CELLS = 10;

    // Per-mode clamps on the digit count.
    localparam logic [5:0] MAX_DEC_DIGITS = 6'd10;
    localparam logic [5:0] MAX_HEX_DIGITS = 6'd8;
    localparam logic [5:0] MAX_BIN_DIGITS = 6'd32;

    // ASCII codes.
    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_A     = 7'h41;
    localparam logic [6:0] CHAR_PLUS  = 7'h2B;
    localparam logic [6:0] CHAR_MINUS = 7'h2D;

    // Formatting modes.
    typedef enum logic [1:0] {
        OP_UDEC = 2'd0,
        OP_SDEC = 2'd1,
        OP_HEX  = 2'd2,
        OP_BIN  = 2'd3
    } n2a_op_t;

    // Control word broadcast to every cell of the row.
    typedef struct packed {
        logic clear;
        logic shift;
        logic decimal;
    } n2a_cell_ctrl_t;

    // Digit value 0-15 to ASCII '0'-'9' or 'A'-'F'.
    function automatic logic [6:0] digit_to_ascii(input logic [3:0] d);
        logic [6:0] code;
        if (d < 4'd10)
        begin
            code = CHAR_ZERO + {3'b000, d};
        end
        else
        begin
            code = CHAR_A + {3'b000, d} - 7'd10;
        end
        return code;
    endfunction

endpackage

// ----- hdl/n2a_digit_cell.sv -----
// One 4-bit digit cell of the shift-and-add-3 conversion row.
// Depends on n2a_pkg for the control word type.
module n2a_digit_cell (
    input  logic                    clk,
    input  n2a_pkg::n2a_cell_ctrl_t ctrl,
    input  logic                    shift_in,
    output logic                    shift_out,
    output logic [3:0]              digit
);
    import n2a_pkg::*;

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] corrected;

    // In decimal mode a digit of five or more gets three added before it
    // doubles, so the carry into the next cell is a decimal carry.
    always_comb
    begin
        if (ctrl.decimal && (digit_reg >= 4'd5))
        begin
            corrected = digit_reg + 4'd3;
        end
        else
        begin
            corrected = digit_reg;
        end
    end

    assign shift_out = corrected[3];

    // Clear on a new word, shift one bit up the row while shift is set, otherwise hold.
    always_comb
    begin
        if (ctrl.clear)
        begin
            digit_next = 4'd0;
        end
        else if (ctrl.shift)
        begin
            digit_next = {corrected[2:0], shift_in};
        end
        else
        begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign digit = digit_reg;

endmodule

// ----- hdl/number_to_ascii_digits_core.sv -----
// Top level of the number to ASCII digits formatter.
// Depends on n2a_pkg and instantiates a row of n2a_digit_cell.
//
// Usage: drive opcode, number, digit_count, row and start_column and raise
// start. A word is taken at a rising edge with start high and busy low.
// The number is shifted, most significant bit first, through a row of ten
// 4-bit digit cells, one bit per cycle; in decimal modes each cell applies
// the add-3 correction, so once every bit is in, the row holds the low
// ten decimal digits, or the low bits of the value for hex and binary.
// Characters then leave one per cycle, most significant digit first, each
// on row_out, column_out, char_code and last for exactly one cycle with
// strobe high. In signed mode the sign character comes first.
// The controller steps from the convert state to the sign state (signed mode
// only) and then, if any digits are asked for, to the emit state; characters
// are registered outputs, and busy falls as the last character is registered.
// The receiver cannot stall: every character is taken in its strobe cycle.
// Reset returns the controller to idle with no strobe pending.
module number_to_ascii_digits_core #(
    parameter int NUMBER_WIDTH = n2a_pkg::NUMBER_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   opcode,
    input  logic [n2a_pkg::NUMBER_BITS-1:0] number,
    input  logic [5:0]                   digit_count,
    input  logic [7:0]                   row,
    input  logic [7:0]                   start_column,
    output logic                         strobe,
    output logic [7:0]                   row_out,
    output logic [7:0]                   column_out,
    output logic [6:0]                   char_code,
    output logic                         last
);
    import n2a_pkg::*;

    localparam int CNT_W = $clog2(NUMBER_WIDTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIGN,
        ST_EMIT
    } state_t;

    state_t                  state_reg, state_next;
    n2a_op_t                 op_reg, op_next;
    logic                    neg_reg, neg_next;
    logic [5:0]              cnt_reg, cnt_next;
    logic [7:0]              row_reg, row_next;
    logic [7:0]              col_reg, col_next;
    logic [NUMBER_WIDTH-1:0] shift_reg, shift_next;
    logic [CNT_W-1:0]        bit_cnt_reg, bit_cnt_next;
    logic                    strobe_reg, strobe_next;
    logic [7:0]              col_out_reg, col_out_next;
    logic [6:0]              char_reg, char_next;
    logic                    last_reg, last_next;

    logic [NUMBER_WIDTH-1:0] value_w;
    logic [NUMBER_WIDTH-1:0] magnitude;
    logic                    in_neg;
    logic [5:0]              clamped;
    logic                    accept;
    n2a_cell_ctrl_t          cell_ctrl;
    logic [NUM_CELLS:0]      chain;
    logic [3:0]              digits [NUM_CELLS];
    logic [31:0]             bin_bits;
    logic [4:0]              pos;
    logic [3:0]              sel_digit;

    // Bring the number port to the internal width.
    generate
        if (NUMBER_WIDTH > NUMBER_BITS)
        begin : g_widen
            assign value_w = {{(NUMBER_WIDTH - NUMBER_BITS){1'b0}}, number};
        end
        else if (NUMBER_WIDTH == NUMBER_BITS)
        begin : g_same
            assign value_w = number;
        end
        else
        begin : g_narrow
            assign value_w = number[NUMBER_WIDTH-1:0];
        end
    endgenerate

    // Sign and magnitude of the incoming word.
    assign in_neg    = (opcode == OP_SDEC) && value_w[NUMBER_WIDTH-1];
    assign magnitude = in_neg ? (~value_w + NUMBER_WIDTH'(1)) : value_w;

    // Clamp the digit count per mode.
    always_comb
    begin
        unique case (n2a_op_t'(opcode))
            OP_HEX:
            begin
                clamped = (digit_count > MAX_HEX_DIGITS) ? MAX_HEX_DIGITS : digit_count;
            end
            OP_BIN:
            begin
                clamped = (digit_count > MAX_BIN_DIGITS) ? MAX_BIN_DIGITS : digit_count;
            end
            default:
            begin
                clamped = (digit_count > MAX_DEC_DIGITS) ? MAX_DEC_DIGITS : digit_count;
            end
        endcase
    end

    assign accept = (state_reg == ST_IDLE) && start;

    // Control word for the cell row.
    assign cell_ctrl.clear   = accept;
    assign cell_ctrl.shift   = (state_reg == ST_CONVERT);
    assign cell_ctrl.decimal = (op_reg == OP_UDEC) || (op_reg == OP_SDEC);

    // Row of digit cells; cell 0 takes the next bit of the number.
    assign chain[0] = shift_reg[NUMBER_WIDTH-1];

    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cells
        n2a_digit_cell u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl),
            .shift_in  (chain[k]),
            .shift_out (chain[k+1]),
            .digit     (digits[k])
        );
    end

    // The low 32 bits of the row, for binary mode.
    for (genvar k = 0; k < 8; k++)
    begin : g_bits
        assign bin_bits[4*k +: 4] = digits[k];
    end

    // Position of the next digit to leave, counted from the least significant.
    assign pos = cnt_reg[4:0] - 5'd1;

    always_comb
    begin
        sel_digit = 4'd0;
        if (op_reg == OP_BIN)
        begin
            sel_digit = {3'b000, bin_bits[pos]};
        end
        else
        begin
            for (int k = 0; k < NUM_CELLS; k++)
            begin
                if (pos == 5'(k))
                begin
                    sel_digit = digits[k];
                end
            end
        end
    end

    // Next-state and output logic of the controller.
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        neg_next     = neg_reg;
        cnt_next     = cnt_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        shift_next   = shift_reg;
        bit_cnt_next = bit_cnt_reg;
        strobe_next  = 1'b0;
        col_out_next = col_out_reg;
        char_next    = char_reg;
        last_next    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next      = n2a_op_t'(opcode);
                    neg_next     = in_neg;
                    cnt_next     = clamped;
                    row_next     = row;
                    col_next     = start_column;
                    shift_next   = magnitude;
                    bit_cnt_next = CNT_W'(NUMBER_WIDTH);
                    state_next   = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                shift_next   = {shift_reg[NUMBER_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - CNT_W'(1);
                if (bit_cnt_reg == CNT_W'(1))
                begin
                    if (op_reg == OP_SDEC)
                    begin
                        state_next = ST_SIGN;
                    end
                    else if (cnt_reg == 6'd0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SIGN:
            begin
                strobe_next  = 1'b1;
                char_next    = neg_reg ? CHAR_MINUS : CHAR_PLUS;
                col_out_next = col_reg;
                col_next     = col_reg + 8'd1;
                last_next    = (cnt_reg == 6'd0);
                state_next   = (cnt_reg == 6'd0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                strobe_next  = 1'b1;
                char_next    = digit_to_ascii(sel_digit);
                col_out_next = col_reg;
                col_next     = col_reg + 8'd1;
                cnt_next     = cnt_reg - 6'd1;
                last_next    = (cnt_reg == 6'd1);
                if (cnt_reg == 6'd1)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_UDEC;
            neg_reg     <= 1'b0;
            cnt_reg     <= 6'd0;
            row_reg     <= 8'd0;
            col_reg     <= 8'd0;
            shift_reg   <= '0;
            bit_cnt_reg <= '0;
            strobe_reg  <= 1'b0;
            col_out_reg <= 8'd0;
            char_reg    <= 7'd0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            neg_reg     <= neg_next;
            cnt_reg     <= cnt_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            shift_reg   <= shift_next;
            bit_cnt_reg <= bit_cnt_next;
            strobe_reg  <= strobe_next;
            col_out_reg <= col_out_next;
            char_reg    <= char_next;
            last_reg    <= last_next;
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign strobe     = strobe_reg;
    assign row_out    = row_reg;
    assign column_out = col_out_reg;
    assign char_code  = char_reg;
    assign last       = last_reg;

`ifndef SYNTHESIS
    // A character only appears as the tail of a word in progress.
    a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("character strobed without a word in progress");

    // An accepted word keeps the block busy while it converts.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start conversion");

    // Characters of one word leave back to back.
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |=> strobe)
        else $error("gap inside a run of characters");

    // Nothing follows the last character directly.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !strobe)
        else $error("character strobed right after the last one");
`endif

endmodule
